// ===== design/efsu_pkg.sv =====
// efsu_pkg: constants, types and state encodings shared by the frame sync / unpack block
// no dependencies; compiled first
`timescale 1ns / 1ps

package efsu_pkg;

    // frame format
    localparam int FRAME_BYTES = 204;
    localparam int SYNC_BYTES  = 4;
    localparam int HEADER_SKIP = 12;
    localparam int CHANNELS    = 16;
    localparam int ROWS        = 4;
    localparam int WIN_LEN     = FRAME_BYTES + SYNC_BYTES;
    localparam int SAMPLES     = ROWS * CHANNELS;

    localparam logic [SYNC_BYTES*8-1:0] SYNC_WORD = 32'h3E46_5290;

    // byte ring: deep enough that a full frame stays readable while later bytes arrive
    localparam int RAM_DEPTH = 256;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    // distance from the newest byte back to the end of the leading sync word
    localparam int SYNC_LAG    = FRAME_BYTES;
    // distance from the next write address back to the first payload byte
    localparam int PAYLOAD_LAG = WIN_LEN - HEADER_SKIP;

    localparam int FILL_W  = $clog2(WIN_LEN + 1);
    localparam int BLACK_W = $clog2(FRAME_BYTES);
    localparam int K_W     = $clog2(SAMPLES);

    // sample arithmetic
    localparam int CODE_W      = 24;
    localparam int SCALE_W     = 16;
    localparam int SCALE_SHIFT = 12;
    localparam int PROD_W      = CODE_W + SCALE_W;
    localparam int UV_W        = PROD_W - SCALE_SHIFT;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd46875;

    localparam int ROW_W = 2;
    localparam int CH_W  = 4;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [7:0]        t_byte;

    // lowest ring address still needed by the unpacker
    typedef struct packed {
        logic  active;
        t_addr addr;
    } t_guard;

    // byte ring write request from the front end
    typedef struct packed {
        logic  we;
        t_addr addr;
        t_byte data;
    } t_ring_wr;

    typedef enum logic {
        F_IDLE,
        F_CHECK
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RD0,
        B_RD1,
        B_RD2,
        B_LO,
        B_MUL,
        B_OUT
    } t_back_state;

endpackage

// ===== design/efsu_if.sv =====
// efsu_if: valid/ready channel interfaces for bytes, samples and the scale register
// depends on efsu_pkg
`timescale 1ns / 1ps

interface efsu_byte_if;
    logic            valid;
    logic            ready;
    efsu_pkg::t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface efsu_sample_if;
    logic                                valid;
    logic                                ready;
    logic [efsu_pkg::ROW_W-1:0]          row_index;
    logic [efsu_pkg::CH_W-1:0]           channel_index;
    logic signed [efsu_pkg::CODE_W-1:0] sample_code;
    logic signed [efsu_pkg::UV_W-1:0]   microvolts_q8;
    logic                                last_of_frame;

    modport source (output valid, output row_index, output channel_index,
                    output sample_code, output microvolts_q8, output last_of_frame,
                    input ready);
    modport sink   (input valid, input row_index, input channel_index,
                    input sample_code, input microvolts_q8, input last_of_frame,
                    output ready);
endinterface

interface efsu_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [efsu_pkg::SCALE_W-1:0]     scale_factor;

    modport source (output valid, output scale_factor, input ready);
    modport sink   (input valid, input scale_factor, output ready);
endinterface

// ===== design/efsu_ram.sv =====
// efsu_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module efsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/efsu_front.sv =====
// efsu_front: takes bytes, writes the byte ring, tracks sync matches and flags frames
// depends on efsu_pkg, efsu_if, efsu_ram
`timescale 1ns / 1ps

module efsu_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    efsu_byte_if.sink             i_byte,
    input  efsu_pkg::t_guard      i_guard,
    input  logic                  i_fifo_full,
    output efsu_pkg::t_ring_wr    o_ring_wr,
    output logic                  o_push,
    output efsu_pkg::t_addr       o_push_addr
);

    efsu_pkg::t_front_state r_state, n_state;

    efsu_pkg::t_addr                          r_wr_ptr;
    logic [(efsu_pkg::SYNC_BYTES-1)*8-1:0]   r_last3;
    logic                                     r_match;
    logic [efsu_pkg::FILL_W-1:0]              r_fill;
    logic [efsu_pkg::BLACK_W-1:0]             r_blackout;

    logic accept;
    logic match_now;
    logic flag_rd;
    logic detect;
    logic ring_block;

    assign match_now  = ({r_last3, i_byte.data_byte} == efsu_pkg::SYNC_WORD);
    assign accept     = i_byte.valid && i_byte.ready;
    assign ring_block = i_guard.active && (i_guard.addr == r_wr_ptr);

    // one flag per ring entry: sync word ends at this byte
    efsu_ram #(
        .WIDTH (1),
        .DEPTH (efsu_pkg::RAM_DEPTH)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wr_ptr),
        .i_wdata (match_now),
        .i_re    (accept),
        .i_raddr (r_wr_ptr - efsu_pkg::ADDR_W'(efsu_pkg::SYNC_LAG)),
        .o_rdata (flag_rd)
    );

    assign detect = (r_blackout == '0) &&
                    (r_fill == efsu_pkg::FILL_W'(efsu_pkg::WIN_LEN)) &&
                    flag_rd && r_match;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            efsu_pkg::F_IDLE:  if (accept) n_state = efsu_pkg::F_CHECK;
            efsu_pkg::F_CHECK: n_state = efsu_pkg::F_IDLE;
            default:           n_state = efsu_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        i_byte.ready = 1'b0;
        o_push       = 1'b0;
        unique case (r_state)
            efsu_pkg::F_IDLE:  i_byte.ready = !i_fifo_full && !ring_block;
            efsu_pkg::F_CHECK: o_push = detect;
            default: ;
        endcase
    end

    assign o_push_addr = r_wr_ptr - efsu_pkg::ADDR_W'(efsu_pkg::PAYLOAD_LAG);

    assign o_ring_wr.we   = accept;
    assign o_ring_wr.addr = r_wr_ptr;
    assign o_ring_wr.data = i_byte.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= efsu_pkg::F_IDLE;
            r_wr_ptr   <= '0;
            r_last3    <= '0;
            r_match    <= 1'b0;
            r_fill     <= '0;
            r_blackout <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_last3  <= {r_last3[(efsu_pkg::SYNC_BYTES-2)*8-1:0], i_byte.data_byte};
                r_match  <= match_now;
                r_wr_ptr <= r_wr_ptr + 1'b1;
                if (r_fill != efsu_pkg::FILL_W'(efsu_pkg::WIN_LEN)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (r_state == efsu_pkg::F_CHECK) begin
                if (r_blackout != '0) begin
                    r_blackout <= r_blackout - 1'b1;
                end else if (detect) begin
                    r_blackout <= efsu_pkg::BLACK_W'(efsu_pkg::FRAME_BYTES - 1);
                end
            end
        end
    end

endmodule

// ===== design/efsu_fifo.sv =====
// efsu_fifo: short queue of frame payload start addresses between front and back
// depends on efsu_pkg
`timescale 1ns / 1ps

module efsu_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  efsu_pkg::t_addr i_push_addr,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output efsu_pkg::t_addr o_head
);

    efsu_pkg::t_addr                     r_mem [efsu_pkg::FIFO_DEPTH];
    logic [efsu_pkg::FIFO_AW-1:0]        r_wr;
    logic [efsu_pkg::FIFO_AW-1:0]        r_rd;
    logic [efsu_pkg::FIFO_AW:0]          r_count;

    assign o_full  = (r_count == (efsu_pkg::FIFO_AW+1)'(efsu_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_push_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 1'b1;
            if (i_pop && !o_empty) r_rd <= r_rd + 1'b1;
            priority if ((i_push && !o_full) && !(i_pop && !o_empty)) begin
                r_count <= r_count + 1'b1;
            end else if (!(i_push && !o_full) && (i_pop && !o_empty)) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/efsu_back.sv =====
// efsu_back: reads a frame payload from the byte ring, builds 24-bit samples, scales them
// depends on efsu_pkg, efsu_if
`timescale 1ns / 1ps

module efsu_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fifo_empty,
    input  efsu_pkg::t_addr              i_fifo_head,
    output logic                         o_pop,
    input  logic [efsu_pkg::SCALE_W-1:0] i_scale,
    output logic                         o_ring_re,
    output efsu_pkg::t_addr              o_ring_raddr,
    input  efsu_pkg::t_byte              i_ring_rdata,
    output efsu_pkg::t_guard             o_guard,
    efsu_sample_if.source                o_smp
);

    efsu_pkg::t_back_state r_state, n_state;

    efsu_pkg::t_addr                        r_rd_addr;
    logic [efsu_pkg::K_W-1:0]               r_k;
    logic [efsu_pkg::CODE_W-1:0]            r_code;
    logic signed [efsu_pkg::PROD_W-1:0]     r_prod;

    logic                                   r_out_valid;
    logic [efsu_pkg::ROW_W-1:0]             r_row;
    logic [efsu_pkg::CH_W-1:0]              r_ch;
    logic signed [efsu_pkg::CODE_W-1:0]     r_code_out;
    logic signed [efsu_pkg::UV_W-1:0]       r_uv;
    logic                                   r_last;

    logic out_load;
    logic last_k;

    assign last_k = (r_k == efsu_pkg::K_W'(efsu_pkg::SAMPLES - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            efsu_pkg::B_IDLE: if (!i_fifo_empty) n_state = efsu_pkg::B_RD0;
            efsu_pkg::B_RD0:  n_state = efsu_pkg::B_RD1;
            efsu_pkg::B_RD1:  n_state = efsu_pkg::B_RD2;
            efsu_pkg::B_RD2:  n_state = efsu_pkg::B_LO;
            efsu_pkg::B_LO:   n_state = efsu_pkg::B_MUL;
            efsu_pkg::B_MUL:  n_state = efsu_pkg::B_OUT;
            efsu_pkg::B_OUT: begin
                if (!r_out_valid || o_smp.ready) begin
                    n_state = last_k ? efsu_pkg::B_IDLE : efsu_pkg::B_RD0;
                end
            end
            default:          n_state = efsu_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        o_ring_re = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            efsu_pkg::B_IDLE: o_pop = !i_fifo_empty;
            efsu_pkg::B_RD0,
            efsu_pkg::B_RD1,
            efsu_pkg::B_RD2:  o_ring_re = 1'b1;
            efsu_pkg::B_OUT:  out_load = !r_out_valid || o_smp.ready;
            default: ;
        endcase
    end

    assign o_ring_raddr   = r_rd_addr;
    assign o_guard.active = (r_state != efsu_pkg::B_IDLE);
    assign o_guard.addr   = r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_addr <= i_fifo_head;
        end else if (o_ring_re) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end
        unique case (r_state)
            efsu_pkg::B_RD1: r_code[23:16] <= i_ring_rdata;
            efsu_pkg::B_RD2: r_code[15:8]  <= i_ring_rdata;
            efsu_pkg::B_LO:  r_code[7:0]   <= i_ring_rdata;
            default: ;
        endcase
        if (r_state == efsu_pkg::B_MUL) begin
            // both operands widened to the full product width before the multiply
            r_prod <= $signed({{efsu_pkg::SCALE_W{r_code[efsu_pkg::CODE_W-1]}}, r_code}) *
                      $signed({{efsu_pkg::CODE_W{1'b0}}, i_scale});
        end
        if (out_load) begin
            r_row      <= r_k[efsu_pkg::K_W-1 -: efsu_pkg::ROW_W];
            r_ch       <= r_k[efsu_pkg::CH_W-1:0];
            r_code_out <= $signed(r_code);
            // arithmetic shift keeps floor rounding for negative values
            r_uv       <= r_prod[efsu_pkg::PROD_W-1:efsu_pkg::SCALE_SHIFT];
            r_last     <= last_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= efsu_pkg::B_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_k <= '0;
            end else if (out_load) begin
                r_k <= r_k + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_smp.valid         = r_out_valid;
    assign o_smp.row_index     = r_row;
    assign o_smp.channel_index = r_ch;
    assign o_smp.sample_code   = r_code_out;
    assign o_smp.microvolts_q8 = r_uv;
    assign o_smp.last_of_frame = r_last;

endmodule

// ===== design/eeg_frame_sync_sample_unpack_core.sv =====
// eeg_frame_sync_sample_unpack_core: top level of the frame sync and sample unpacker
// depends on efsu_pkg, efsu_if, efsu_ram, efsu_front, efsu_fifo, efsu_back
//
//  channel   dir   payload                                                  transaction
//  i_byte    in    data_byte[7:0]                                           valid & ready
//  o_smp     out   row_index, channel_index, sample_code, microvolts_q8,    valid & ready
//                  last_of_frame
//  i_cfg     in    scale_factor[15:0]                                       valid & ready
//
// each byte goes through the front end as a ring write, then a sync flag read and decision
// each sample in the back end: three ring reads, a multiply, an output load
// the front end takes no byte while deciding, else stalls only if the frame queue is full or
// the next byte would overwrite unread ring entries; the back end stalls on o_smp.ready alone
// synchronous active-low reset; the byte ring has no reset, a frame is only detected once
// 208 bytes have been written; scale_factor resets to 46875
`timescale 1ns / 1ps

module eeg_frame_sync_sample_unpack_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    efsu_byte_if.sink     i_byte,
    efsu_sample_if.source o_smp,
    efsu_cfg_if.sink      i_cfg
);

    logic [efsu_pkg::SCALE_W-1:0] r_scale;

    efsu_pkg::t_ring_wr ring_wr;
    efsu_pkg::t_guard   back_guard;
    efsu_pkg::t_guard   guard;
    efsu_pkg::t_addr    push_addr;
    efsu_pkg::t_addr    fifo_head;
    efsu_pkg::t_addr    ring_raddr;
    efsu_pkg::t_byte    ring_rdata;
    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;
    logic               ring_re;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= efsu_pkg::SCALE_RESET;
        end else if (i_cfg.valid) begin
            r_scale <= i_cfg.scale_factor;
        end
    end

    // oldest ring entry still needed: the unpacker position, else the queued frame start
    always_comb begin
        if (back_guard.active) begin
            guard = back_guard;
        end else begin
            guard.active = !fifo_empty;
            guard.addr   = fifo_head;
        end
    end

    efsu_ram #(
        .WIDTH (8),
        .DEPTH (efsu_pkg::RAM_DEPTH)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (ring_wr.we),
        .i_waddr (ring_wr.addr),
        .i_wdata (ring_wr.data),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    efsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .i_guard     (guard),
        .i_fifo_full (fifo_full),
        .o_ring_wr   (ring_wr),
        .o_push      (push),
        .o_push_addr (push_addr)
    );

    efsu_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_addr (push_addr),
        .i_pop       (pop),
        .o_full      (fifo_full),
        .o_empty     (fifo_empty),
        .o_head      (fifo_head)
    );

    efsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (fifo_empty),
        .i_fifo_head  (fifo_head),
        .o_pop        (pop),
        .i_scale      (r_scale),
        .o_ring_re    (ring_re),
        .o_ring_raddr (ring_raddr),
        .i_ring_rdata (ring_rdata),
        .o_guard      (back_guard),
        .o_smp        (o_smp)
    );

endmodule
